// ===== rtl/lstt_pkg.sv =====
// Package for the load segment table: word types, codes, state encoding.
// Used by lstt_cell and load_segment_table_translate_top.
package lstt_pkg;

  localparam int unsigned MAX_SEGMENTS_DEF = 16;
  localparam int unsigned SLOT_IDX_W       = 6;   // covers up to 64 slots
  localparam int unsigned SEG_IDX_W        = 4;
  localparam logic [63:0] PAGE_MASK        = 64'h0000_0000_0000_0fff;
  localparam logic [31:0] TYPE_LOADABLE    = 32'd1;
  localparam logic [63:0] HTO_RESET        = 64'd64;
  localparam logic [7:0]  HCOUNT_RESET     = 8'd1;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_ADD   = 2'd1;
  localparam logic [1:0] KIND_XLATE = 2'd2;

  localparam logic CFG_HTO    = 1'b0;
  localparam logic CFG_HCOUNT = 1'b1;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_SKIPPED  = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_MEMSZ    = 3'd3,
    STAT_FIRSTOFF = 3'd4,
    STAT_FIRSTSML = 3'd5,
    STAT_MISALIGN = 3'd6,
    STAT_MISS     = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD_CHK,
    S_ADD_WR,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] seg_type;
    logic [2:0]  seg_flags;
    logic [63:0] seg_vaddr;
    logic [63:0] seg_file_offset;
    logic [63:0] seg_file_size;
    logic [63:0] seg_mem_size;
    logic [63:0] address;
    logic [63:0] length;
  } in_word_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [SEG_IDX_W-1:0] segment_index;
    logic [63:0]          map_base;
    logic [63:0]          map_length;
    logic [1:0]           access_rights;
    logic [63:0]          host_address;
    logic [63:0]          image_end;
    logic [63:0]          header_address;
  } out_word_t;

  // lookup travelling down the cell row
  typedef struct packed {
    logic                  valid;
    logic                  ok;
    logic                  hit;
    logic [SLOT_IDX_W-1:0] idx;
    logic [63:0]           base;
    logic [63:0]           len;
    logic [1:0]            rights;
    logic [63:0]           addr;
    logic [63:0]           last;
  } query_t;

endpackage

// ===== rtl/lstt_cell.sv =====
// One table slot: holds base, length and rights, checks the passing lookup.
// Depends on lstt_pkg.
module lstt_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            active,
  input  logic            wr_en,
  input  logic [63:0]     wr_base,
  input  logic [63:0]     wr_len,
  input  logic [1:0]      wr_rights,
  input  lstt_pkg::query_t q_in,
  output lstt_pkg::query_t q_out
);
  import lstt_pkg::*;

  logic [63:0] base_r;
  logic [63:0] len_r;
  logic [1:0]  rights_r;
  query_t      q_r;
  query_t      q_nxt;
  logic [63:0] seg_end;
  logic        match;

  always_comb begin
    seg_end = base_r + len_r;
    match   = active && q_in.ok && !q_in.hit &&
              (q_in.addr >= base_r) && (q_in.last <= seg_end);
    q_nxt   = q_in;
    if (match) begin
      q_nxt.hit    = 1'b1;
      q_nxt.idx    = SLOT_IDX_W'(IDX);
      q_nxt.base   = base_r;
      q_nxt.len    = len_r;
      q_nxt.rights = rights_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      base_r   <= wr_base;
      len_r    <= wr_len;
      rights_r <= wr_rights;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else begin
      q_r.valid <= q_nxt.valid;
    end
    q_r.ok     <= q_nxt.ok;
    q_r.hit    <= q_nxt.hit;
    q_r.idx    <= q_nxt.idx;
    q_r.base   <= q_nxt.base;
    q_r.len    <= q_nxt.len;
    q_r.rights <= q_nxt.rights;
    q_r.addr   <= q_nxt.addr;
    q_r.last   <= q_nxt.last;
  end

  assign q_out = q_r;

endmodule

// ===== rtl/load_segment_table_translate_top.sv =====
// Load segment table top: control, add checks and the row of slot cells.
// Depends on lstt_pkg and lstt_cell.
// Clear and the unused kind answer straight from idle; add steps through S_ADD_CHK and
// S_ADD_WR; translate walks the lookup down the cell row, one cell per cycle. One item at a
// time: busy drops as the result word is loaded, so a new word is taken only once the
// last one's result is loaded. The receiver cannot stall.
// Reset (synchronous, rst_n low) empties the table and loads register defaults.
module load_segment_table_translate_top #(
  parameter int unsigned MAX_SEGMENTS = lstt_pkg::MAX_SEGMENTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  lstt_pkg::in_word_t  in_word,
  output logic               out_strobe,
  output lstt_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [63:0]        cfg_wdata
);
  import lstt_pkg::*;

  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);

  state_t      state_r, state_nxt;
  in_word_t    req_r;
  logic [CW-1:0] count_r;
  logic        first_r;
  logic [63:0] end_r;
  logic [63:0] hva_r;
  logic [63:0] hto_r;
  logic [7:0]  hc_r;
  logic [63:0] span_r;
  status_t     chk_r;
  status_t     chk;
  logic [63:0] top_r;
  logic [63:0] base_r;
  logic [13:0] hc_ext;
  logic [63:0] diff;
  logic [63:0] len;
  logic [63:0] end_up;
  logic [63:0] hva_new;
  logic [63:0] xl_last;
  logic        accept;
  logic        wr_fire;
  logic        out_strobe_r;
  logic        out_strobe_nxt;
  out_word_t   out_word_r;
  out_word_t   out_word_nxt;
  query_t      q0_r;
  query_t      q [0:MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] active;
  logic [MAX_SEGMENTS-1:0] wr_en;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign hc_ext = {6'b0, hc_r};

  always_comb begin
    xl_last = in_word.address + in_word.length;
    diff    = top_r - base_r;
    len     = (diff + PAGE_MASK) & ~PAGE_MASK;
    end_up  = (top_r + PAGE_MASK) & ~PAGE_MASK;
    hva_new = req_r.seg_vaddr + hto_r;
    wr_fire = (state_r == S_ADD_WR) && (chk_r == STAT_OK);

    if (req_r.seg_type != TYPE_LOADABLE) begin
      chk = STAT_SKIPPED;
    end else if (count_r >= CW'(MAX_SEGMENTS)) begin
      chk = STAT_FULL;
    end else if (req_r.seg_mem_size < req_r.seg_file_size) begin
      chk = STAT_MEMSZ;
    end else if (first_r && (req_r.seg_file_offset != 64'd0)) begin
      chk = STAT_FIRSTOFF;
    end else if (first_r && (req_r.seg_file_size < span_r)) begin
      chk = STAT_FIRSTSML;
    end else if ((req_r.seg_file_offset & PAGE_MASK) != (req_r.seg_vaddr & PAGE_MASK)) begin
      chk = STAT_MISALIGN;
    end else begin
      chk = STAT_OK;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_word.kind == KIND_ADD) begin
          state_nxt = S_ADD_CHK;
        end else if (accept && in_word.kind == KIND_XLATE) begin
          state_nxt = S_SCAN;
        end
      end
      S_ADD_CHK: state_nxt = S_ADD_WR;
      S_ADD_WR:  state_nxt = S_IDLE;
      S_SCAN: begin
        if (q[MAX_SEGMENTS].valid) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hto_r <= HTO_RESET;
      hc_r  <= HCOUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HTO:    hto_r <= cfg_wdata;
        CFG_HCOUNT: hc_r  <= cfg_wdata[7:0];
        default:    ;
      endcase
    end
  end

  // header byte span: offset + count * 56
  always_ff @(posedge clk) begin
    span_r <= hto_r + 64'((hc_ext << 6) - (hc_ext << 3));
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_word;
    end
    if (state_r == S_ADD_CHK) begin
      chk_r  <= chk;
      top_r  <= req_r.seg_vaddr + req_r.seg_mem_size;
      base_r <= req_r.seg_vaddr & ~PAGE_MASK;
    end
  end

  // lookup launch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q0_r.valid <= 1'b0;
    end else begin
      q0_r.valid <= accept && (in_word.kind == KIND_XLATE);
    end
    q0_r.ok     <= (in_word.length != 64'd0) && (xl_last >= in_word.address);
    q0_r.hit    <= 1'b0;
    q0_r.idx    <= '0;
    q0_r.base   <= '0;
    q0_r.len    <= '0;
    q0_r.rights <= '0;
    q0_r.addr   <= in_word.address;
    q0_r.last   <= xl_last;
  end

  assign q[0] = q0_r;

  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    assign active[i] = (CW'(i) < count_r);
    assign wr_en[i]  = wr_fire && (count_r == CW'(i));
    lstt_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .active   (active[i]),
      .wr_en    (wr_en[i]),
      .wr_base  (base_r),
      .wr_len   (len),
      .wr_rights({req_r.seg_flags[1], 1'b1}),
      .q_in     (q[i]),
      .q_out    (q[i+1])
    );
  end

  // result word
  always_comb begin
    out_strobe_nxt = 1'b0;
    out_word_nxt   = '0;
    if (accept && (in_word.kind == KIND_CLEAR)) begin
      out_strobe_nxt      = 1'b1;
      out_word_nxt.status = STAT_OK;
    end else if (accept && (in_word.kind != KIND_ADD) && (in_word.kind != KIND_XLATE)) begin
      out_strobe_nxt              = 1'b1;
      out_word_nxt.status         = STAT_MISS;
      out_word_nxt.image_end      = end_r;
      out_word_nxt.header_address = hva_r;
    end else if (state_r == S_ADD_WR) begin
      out_strobe_nxt      = 1'b1;
      out_word_nxt.status = chk_r;
      if (chk_r == STAT_OK) begin
        out_word_nxt.segment_index  = SEG_IDX_W'(count_r);
        out_word_nxt.map_base       = base_r;
        out_word_nxt.map_length     = len;
        out_word_nxt.access_rights  = {req_r.seg_flags[1], 1'b1};
        out_word_nxt.image_end      = (top_r > end_r) ? end_up : end_r;
        out_word_nxt.header_address = first_r ? hva_new : hva_r;
      end else if (chk_r == STAT_SKIPPED) begin
        out_word_nxt.image_end      = end_r;
        out_word_nxt.header_address = hva_r;
      end
    end else if ((state_r == S_SCAN) && q[MAX_SEGMENTS].valid) begin
      out_strobe_nxt              = 1'b1;
      out_word_nxt.image_end      = end_r;
      out_word_nxt.header_address = hva_r;
      if (q[MAX_SEGMENTS].hit) begin
        out_word_nxt.status        = STAT_OK;
        out_word_nxt.segment_index = SEG_IDX_W'(q[MAX_SEGMENTS].idx);
        out_word_nxt.map_base      = q[MAX_SEGMENTS].base;
        out_word_nxt.map_length    = q[MAX_SEGMENTS].len;
        out_word_nxt.access_rights = q[MAX_SEGMENTS].rights;
        out_word_nxt.host_address  = q[MAX_SEGMENTS].addr;
      end else begin
        out_word_nxt.status = STAT_MISS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_strobe_nxt) begin
      out_word_r <= out_word_nxt;
    end
  end

  // table control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      first_r      <= 1'b1;
      end_r        <= '0;
      hva_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= out_strobe_nxt;
      if (accept && (in_word.kind == KIND_CLEAR)) begin
        count_r <= '0;
        first_r <= 1'b1;
        end_r   <= '0;
        hva_r   <= '0;
      end else if (state_r == S_ADD_WR) begin
        if (chk_r == STAT_OK) begin
          count_r <= count_r + CW'(1);
          first_r <= 1'b0;
          if (top_r > end_r) begin
            end_r <= end_up;
          end
          if (first_r) begin
            hva_r <= hva_new;
          end
        end else if (chk_r != STAT_SKIPPED) begin
          count_r <= '0;
          first_r <= 1'b1;
          end_r   <= '0;
          hva_r   <= '0;
        end
      end
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule
